/* src/mbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package mbn_pkg;

  localparam int TAG_W      = 12;
  localparam int COORD_W    = 32;
  localparam int NORM_W     = 32;
  localparam int ITER_W     = 8;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int FRAC_BITS_DEF = 28;
  localparam int FRAC_MIN      = 16;
  localparam int OUT_FRAC      = 27;

  // Working width of z and of operand magnitudes; the multiplier splits them in two digits.
  localparam int Z_W    = 64;
  localparam int DIG_W  = Z_W / 2;
  localparam int ACC_W  = 2 * Z_W;
  // A truncated product saturates at 2^60, so it needs 61 bits.
  localparam int CAP_LOG = 60;
  localparam int PROD_W  = CAP_LOG + 1;
  // Sum of two squares and its rescaled form.
  localparam int SUM_W   = PROD_W + 1;
  localparam int NORM_X_W = SUM_W + OUT_FRAC - FRAC_MIN;
  localparam int NSAT_W  = NORM_W + 1;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_LIMIT  = 1'b1;

  localparam logic [ITER_W-1:0] MAX_ITER_RST   = 8'd50;
  localparam logic [NORM_W-1:0] ESC_LIMIT_RST  = 32'h1000_0000;

  typedef struct packed {
    logic [TAG_W-1:0]          pixel_x;
    logic [TAG_W-1:0]          pixel_y;
    logic signed [COORD_W-1:0] c_re;
    logic signed [COORD_W-1:0] c_im;
  } in_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  out_x;
    logic [TAG_W-1:0]  out_y;
    logic [NORM_W-1:0] final_norm;
  } out_item_t;

endpackage

`default_nettype wire

/* src/mbn_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

module mbn_mul #(
  parameter int FRAC_BITS = mbn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [mbn_pkg::Z_W-1:0]    a,
  input  wire logic [mbn_pkg::Z_W-1:0]    b,
  output logic                            done,
  output logic [mbn_pkg::PROD_W-1:0]      res
);
  import mbn_pkg::*;

  localparam int LAST_STEP = 5;

  logic [Z_W-1:0]       a_q;
  logic [Z_W-1:0]       b_q;
  logic [2:0]           step;
  logic                 run;
  logic [2*DIG_W-1:0]   pp;
  logic [1:0]           pp_pos;
  logic [ACC_W-1:0]     acc;
  logic [DIG_W-1:0]     a_dig;
  logic [DIG_W-1:0]     b_dig;
  logic [ACC_W-1:0]     addend;
  logic                 sat;

  assign a_dig = step[1] ? a_q[Z_W-1:DIG_W] : a_q[DIG_W-1:0];
  assign b_dig = step[0] ? b_q[Z_W-1:DIG_W] : b_q[DIG_W-1:0];

  always_comb begin
    unique case (pp_pos)
      2'd0:    addend = {{(2*DIG_W){1'b0}}, pp};
      2'd1:    addend = {{DIG_W{1'b0}}, pp, {DIG_W{1'b0}}};
      default: addend = {pp, {(2*DIG_W){1'b0}}};
    endcase
  end

  // The shifted product exceeds 2^60 when any bit above it is set, or it is 2^60 plus a remainder.
  assign sat = (|acc[ACC_W-1:FRAC_BITS+CAP_LOG+1]) ||
               (acc[FRAC_BITS+CAP_LOG] && (|acc[FRAC_BITS+CAP_LOG-1:FRAC_BITS]));

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run  <= 1'b1;
        step <= '0;
        acc  <= '0;
        a_q  <= a;
        b_q  <= b;
      end else if (run) begin
        if (step < 3'd4) begin
          pp     <= a_dig * b_dig;
          pp_pos <= {1'b0, step[1]} + {1'b0, step[0]};
        end
        if (step >= 3'd1 && step <= 3'd4) begin
          acc <= acc + addend;
        end
        if (step == 3'(LAST_STEP)) begin
          res  <= sat ? {1'b1, {CAP_LOG{1'b0}}} : acc[FRAC_BITS+CAP_LOG:FRAC_BITS];
          done <= 1'b1;
          run  <= 1'b0;
        end
        step <= step + 3'd1;
      end
    end
  end

`ifndef ASSERT_OFF
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run))
    else $error("multiplier finished without running");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (run && step <= 3'(LAST_STEP)) |-> !start)
    else $error("multiplier started while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("multiplier done held longer than one cycle");
`endif

endmodule

`default_nettype wire

/* src/mandelbrot_escape_norm.sv */
`timescale 1ns / 1ps
`default_nettype none

// Mandelbrot escape-time unit: each input transfer carries a pixel tag pair and a point c in
// signed Q4.28; z starts at c and z = z*z + c runs at least once, stopping when the count
// reaches max_iterations or the squared magnitude (Q5.27) exceeds escape_limit, and one result
// transfer returns the tags and the final squared magnitude, saturated at all ones. All
// products go through a single 32x32 multiplier, four partial products per full product; each
// product is started in a go state and its result is taken in the matching wait state. One
// iteration needs three products plus a check state and an update state, and the squares of
// the last z are formed once more for the final check. Once the result is loaded into the
// output register the unit returns to idle, where the next input transfer is accepted.
// Only one item is in flight at a time; a finished result waits in the output register while
// the next item is accepted.
module mandelbrot_escape_norm #(
  parameter int FRAC_BITS = mbn_pkg::FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire mbn_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output mbn_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_we,
  input  wire logic [mbn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mbn_pkg::CFG_W-1:0]     cfg_data
);
  import mbn_pkg::*;

  localparam int NSH_L = (FRAC_BITS < OUT_FRAC) ? OUT_FRAC - FRAC_BITS : 0;
  localparam int NSH_R = (FRAC_BITS >= OUT_FRAC) ? FRAC_BITS - OUT_FRAC : 0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_XX_GO,
    S_XX_WAIT,
    S_YY_GO,
    S_YY_WAIT,
    S_CHK,
    S_XY_GO,
    S_XY_WAIT,
    S_UPD,
    S_OUT
  } state_t;

  state_t                state;
  logic [ITER_W-1:0]     max_iter;
  logic [NORM_W-1:0]     esc_limit;
  logic [TAG_W-1:0]      tag_x;
  logic [TAG_W-1:0]      tag_y;
  logic signed [Z_W-1:0] cr;
  logic signed [Z_W-1:0] ci;
  logic signed [Z_W-1:0] zr;
  logic signed [Z_W-1:0] zi;
  logic [ITER_W-1:0]     count;
  logic [PROD_W-1:0]     xx;
  logic [PROD_W-1:0]     yy;
  logic [PROD_W-1:0]     xy;
  logic                  xy_neg;
  logic [NSAT_W-1:0]     norm;

  logic [Z_W-1:0]        mag_r;
  logic [Z_W-1:0]        mag_i;
  logic [Z_W-1:0]        mul_a;
  logic [Z_W-1:0]        mul_b;
  logic                  mul_start;
  logic                  mul_done;
  logic [PROD_W-1:0]     mul_res;

  logic [SUM_W-1:0]      sq_sum;
  logic [NORM_X_W-1:0]   norm_x;
  logic [NSAT_W-1:0]     norm_next;
  logic                  stop;
  logic signed [Z_W-1:0] xy2;
  logic signed [Z_W-1:0] zr_next;
  logic signed [Z_W-1:0] zi_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_iter  <= MAX_ITER_RST;
      esc_limit <= ESC_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_ITER:  max_iter  <= cfg_data[ITER_W-1:0];
        REG_ESC_LIMIT: esc_limit <= cfg_data[NORM_W-1:0];
      endcase
    end
  end

  assign mag_r = zr[Z_W-1] ? Z_W'(-zr) : Z_W'(zr);
  assign mag_i = zi[Z_W-1] ? Z_W'(-zi) : Z_W'(zi);

  always_comb begin
    unique case (state)
      S_XX_GO: begin
        mul_a = mag_r;
        mul_b = mag_r;
      end
      S_YY_GO: begin
        mul_a = mag_i;
        mul_b = mag_i;
      end
      default: begin
        mul_a = mag_r;
        mul_b = mag_i;
      end
    endcase
  end

  assign mul_start = (state == S_XX_GO) || (state == S_YY_GO) || (state == S_XY_GO);

  mbn_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  // The squares of the current z also give its squared magnitude.
  assign sq_sum    = {1'b0, xx} + {1'b0, yy};
  assign norm_x    = (NORM_X_W'(sq_sum) << NSH_L) >> NSH_R;
  assign norm_next = (norm_x > NORM_X_W'({1'b1, {NORM_W{1'b0}}})) ?
                     {1'b1, {NORM_W{1'b0}}} : norm_x[NSAT_W-1:0];
  assign stop      = (count != '0) &&
                     ((count >= max_iter) || (norm_next > {1'b0, esc_limit}));

  assign xy2     = $signed({2'b00, xy, 1'b0});
  assign zr_next = $signed({3'b000, xx}) - $signed({3'b000, yy}) + cr;
  assign zi_next = (xy_neg ? -xy2 : xy2) + ci;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (state == S_OUT) || (out_valid && !out_ready);
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            tag_x <= in_data.pixel_x;
            tag_y <= in_data.pixel_y;
            cr    <= Z_W'(in_data.c_re);
            ci    <= Z_W'(in_data.c_im);
            zr    <= Z_W'(in_data.c_re);
            zi    <= Z_W'(in_data.c_im);
            count <= '0;
            state <= S_XX_GO;
          end
        end
        S_XX_GO: state <= S_XX_WAIT;
        S_XX_WAIT: begin
          if (mul_done) begin
            xx    <= mul_res;
            state <= S_YY_GO;
          end
        end
        S_YY_GO: state <= S_YY_WAIT;
        S_YY_WAIT: begin
          if (mul_done) begin
            yy    <= mul_res;
            state <= S_CHK;
          end
        end
        S_CHK: begin
          norm  <= norm_next;
          state <= stop ? S_OUT : S_XY_GO;
        end
        S_XY_GO: begin
          xy_neg <= zr[Z_W-1] ^ zi[Z_W-1];
          state  <= S_XY_WAIT;
        end
        S_XY_WAIT: begin
          if (mul_done) begin
            xy    <= mul_res;
            state <= S_UPD;
          end
        end
        S_UPD: begin
          zr    <= zr_next;
          zi    <= zi_next;
          count <= count + ITER_W'(1);
          state <= S_XX_GO;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_data.out_x      <= tag_x;
            out_data.out_y      <= tag_y;
            out_data.final_norm <= norm[NORM_W] ? {NORM_W{1'b1}} : norm[NORM_W-1:0];
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == S_XX_GO))
    else $error("accepted item did not start the first square");
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_XX_WAIT || state == S_YY_WAIT || state == S_XY_WAIT))
    else $error("multiplier result arrived outside a wait state");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |-> (count == '0 || count < max_iter))
    else $error("iteration continued past the limit");
  a_out_from_chk: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_OUT) |-> $past(state == S_CHK))
    else $error("result stage entered without a stop check");
`endif

endmodule

`default_nettype wire

/* sim/tb_mandelbrot_escape_norm.sv */
`timescale 1ns / 1ps

module tb_mandelbrot_escape_norm;
  import mbn_pkg::*;

  localparam int          LONG_HOLD   = 1500;
  localparam int          STALL_LIMIT = 30000;
  localparam logic [127:0] PROD_CAP   = 128'd1 << CAP_LOG;
  localparam logic [62:0]  NORM_CAP   = 63'd1 << NORM_W;

  typedef struct {
    logic [ITER_W-1:0] iter;
    logic [NORM_W-1:0] esc;
    in_item_t          item;
    bit                known;
    logic [NORM_W-1:0] norm;
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_MAX_ITER;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [ITER_W-1:0] lim_iter = MAX_ITER_RST;
  logic [NORM_W-1:0] lim_esc = ESC_LIMIT_RST;
  out_item_t         escape_q[$];
  int                mismatches = 0;
  int                idle_cycles = 0;
  bit                hold_req = 1'b0;
  stim_row_t         rows[$];

  mandelbrot_escape_norm u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [63:0] abs64(input logic [63:0] v);
    abs64 = v[63] ? (~v + 64'd1) : v;
  endfunction

  function automatic logic [PROD_W-1:0] mag_prod(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> FRAC_BITS_DEF;
    mag_prod = (p > PROD_CAP) ? PROD_CAP[PROD_W-1:0] : p[PROD_W-1:0];
  endfunction

  function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic signed [63:0] p;
    p = $signed({3'b000, mag_prod(abs64(a), abs64(b))});
    fx_mul = (a[63] ^ b[63]) ? -p : p;
  endfunction

  function automatic logic [NORM_W:0] norm_q527(input logic signed [63:0] re,
                                                input logic signed [63:0] im);
    logic [62:0] s;
    logic [62:0] n;
    s = {2'b00, mag_prod(abs64(re), abs64(re))} + {2'b00, mag_prod(abs64(im), abs64(im))};
    n = s >> (FRAC_BITS_DEF - OUT_FRAC);
    norm_q527 = (n > NORM_CAP) ? NORM_CAP[NORM_W:0] : n[NORM_W:0];
  endfunction

  function automatic out_item_t predict_escape(input in_item_t it);
    logic signed [63:0] cr, ci, zr, zi, xx, yy, xy;
    logic [NORM_W:0]    n;
    int                 count;
    bit                 done;
    out_item_t          res;
    cr = {{32{it.c_re[COORD_W-1]}}, it.c_re};
    ci = {{32{it.c_im[COORD_W-1]}}, it.c_im};
    zr = cr;
    zi = ci;
    count = 0;
    done = 1'b0;
    n = '0;
    while (!done) begin
      xx = fx_mul(zr, zr);
      yy = fx_mul(zi, zi);
      xy = fx_mul(zr, zi);
      zr = xx - yy + cr;
      zi = xy + xy + ci;
      count++;
      n = norm_q527(zr, zi);
      done = (count >= lim_iter) || (n > {1'b0, lim_esc});
    end
    res.out_x = it.pixel_x;
    res.out_y = it.pixel_y;
    res.final_norm = n[NORM_W] ? {NORM_W{1'b1}} : n[NORM_W-1:0];
    predict_escape = res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) pick_gap = 0;
    else if (r < 90) pick_gap = $urandom_range(1, 3);
    else if (r < 97) pick_gap = $urandom_range(4, 12);
    else pick_gap = $urandom_range(30, 120);
  endfunction

  function automatic logic [COORD_W-1:0] pick_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) pick_coord = $urandom();
    else if (r < 8) pick_coord = $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
    else pick_coord = $urandom_range(0, 32'h1000_0000) - 32'h0800_0000;
  endfunction

  function automatic stim_row_t mk_row(input logic [ITER_W-1:0] iter,
                                       input logic [NORM_W-1:0] esc,
                                       input logic [TAG_W-1:0] x, input logic [TAG_W-1:0] y,
                                       input logic [COORD_W-1:0] re,
                                       input logic [COORD_W-1:0] im,
                                       input bit known, input logic [NORM_W-1:0] norm);
    stim_row_t r;
    r.iter = iter;
    r.esc = esc;
    r.item.pixel_x = x;
    r.item.pixel_y = y;
    r.item.c_re = re;
    r.item.c_im = im;
    r.known = known;
    r.norm = norm;
    mk_row = r;
  endfunction

  function automatic void add_row(input stim_row_t r);
    rows.insert(rows.size(), r);
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    mismatches++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (escape_q.size() == 0) begin
      report_mismatch("unexpected result", got.final_norm, '0);
    end else begin
      want = escape_q.pop_front();
      if (got.out_x !== want.out_x) report_mismatch("out_x", got.out_x, want.out_x);
      if (got.out_y !== want.out_y) report_mismatch("out_y", got.out_y, want.out_y);
      if (got.final_norm !== want.final_norm)
        report_mismatch("final_norm", got.final_norm, want.final_norm);
    end
  endtask

  task automatic push_pixel(input in_item_t it, input bit known,
                            input logic [NORM_W-1:0] norm);
    out_item_t exp;
    int        gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (known) begin
      exp.out_x = it.pixel_x;
      exp.out_y = it.pixel_y;
      exp.final_norm = norm;
    end else begin
      exp = predict_escape(it);
    end
    escape_q.insert(escape_q.size(), exp);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic stop_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (escape_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limits(input logic [ITER_W-1:0] iter, input logic [NORM_W-1:0] esc);
    logic [31:0] junk;
    junk = $urandom();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_MAX_ITER;
    cfg_data <= {junk[31:8], iter};
    @(negedge clk);
    cfg_index <= REG_ESC_LIMIT;
    cfg_data <= esc;
    lim_iter = iter;
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_esc = esc;
  endtask

  task automatic run_phase(input logic [ITER_W-1:0] iter, input logic [NORM_W-1:0] esc,
                           input int count);
    in_item_t it;
    stop_input();
    wait_drained();
    write_limits(iter, esc);
    for (int i = 0; i < count; i++) begin
      it.pixel_x = $urandom_range(0, 4095);
      it.pixel_y = $urandom_range(0, 4095);
      it.c_re = pick_coord();
      it.c_im = pick_coord();
      push_pixel(it, 1'b0, '0);
      if (i > 0 && $urandom_range(0, 99) == 0) begin
        stop_input();
        wait_drained();
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h000, 12'h000, 32'h0000_0000,
                   32'h0000_0000, 1'b1, 32'h0000_0000));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'hFFF, 12'hFFF, 32'h0000_0000,
                   32'h0000_0000, 1'b1, 32'h0000_0000));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'hFFF, 12'h000, 32'h8000_0000,
                   32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h000, 12'hFFF, 32'h7FFF_FFFF,
                   32'h7FFF_FFFF, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'hAAA, 12'h555, 32'h8000_0000,
                   32'h8000_0000, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h555, 12'hAAA, 32'h0000_0000,
                   32'h8000_0000, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h001, 12'h800, 32'h7FFF_FFFF,
                   32'h8000_0000, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h800, 12'h001, 32'hF000_0000,
                   32'h0000_0000, 1'b0, '0));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h123, 12'h456, 32'h1000_0000,
                   32'h0000_0000, 1'b0, '0));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h789, 12'hABC, 32'hE000_0000,
                   32'h0000_0000, 1'b0, '0));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'hDEF, 12'h321, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 1'b0, '0));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h654, 12'h987, 32'h0000_0001,
                   32'h0000_0001, 1'b0, '0));
    add_row(mk_row(8'd50, 32'h1000_0000, 12'h0F0, 12'hF0F, 32'h0400_0000,
                   32'h0400_0000, 1'b0, '0));
    // A zero iteration limit still runs one iteration.
    add_row(mk_row(8'd0, 32'h1000_0000, 12'h111, 12'h222, 32'h1000_0000,
                   32'h0000_0000, 1'b1, 32'h2000_0000));
    add_row(mk_row(8'd0, 32'h1000_0000, 12'h333, 12'h444, 32'h0000_0000,
                   32'h0000_0000, 1'b1, 32'h0000_0000));
    add_row(mk_row(8'd1, 32'h0000_0000, 12'h666, 12'h777, 32'h0800_0000,
                   32'hF800_0000, 1'b0, '0));
    // With the limit at its maximum only a saturated norm escapes.
    add_row(mk_row(8'd255, 32'hFFFF_FFFF, 12'h888, 12'h999, 32'h8000_0000,
                   32'h0000_0000, 1'b1, 32'hFFFF_FFFF));
    add_row(mk_row(8'd255, 32'hFFFF_FFFF, 12'hBBB, 12'hCCC, 32'h0000_0000,
                   32'h0000_0000, 1'b1, 32'h0000_0000));
    add_row(mk_row(8'd255, 32'hFFFF_FFFF, 12'hEEE, 12'hDDD, 32'hF000_0000,
                   32'h0000_0000, 1'b0, '0));
    add_row(mk_row(8'd255, 32'h0000_0000, 12'h0AA, 12'h0BB, 32'h0000_0000,
                   32'h0000_0000, 1'b1, 32'h0000_0000));
    add_row(mk_row(8'd255, 32'h0000_0000, 12'h0CC, 12'h0DD, 32'h0000_0001,
                   32'h0000_0000, 1'b0, '0));
    add_row(mk_row(8'd2, 32'h8000_0000, 12'h5A5, 12'hA5A, 32'h1800_0000,
                   32'hE800_0000, 1'b0, '0));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      if (rows[i].iter != lim_iter || rows[i].esc != lim_esc) begin
        stop_input();
        wait_drained();
        write_limits(rows[i].iter, rows[i].esc);
      end
      push_pixel(rows[i].item, rows[i].known, rows[i].norm);
    end

    run_phase(8'd50, 32'h1000_0000, 220);
    run_phase(8'd1, $urandom(), 150);
    run_phase(8'd255, 32'hFFFF_FFFF, 12);
    run_phase(8'd0, 32'h0000_0000, 100);
    // The long hold-off starts once items of the next phase are flowing.
    fork
      begin
        wait (lim_iter == 8'd12);
        repeat (200) @(posedge clk);
        hold_req = 1'b1;
      end
    join_none
    run_phase(8'd12, 32'h2000_0000, 200);
    run_phase(8'd8, $urandom(), 150);
    run_phase(8'd255, 32'h0000_0000, 6);
    run_phase(8'd20, $urandom_range(0, 32'h3000_0000), 200);
    run_phase(8'd30, 32'h1000_0000, 60);

    stop_input();
    while (escape_q.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
